>>> hdl/encoder_period_averager_assert.svh
// ----------------------------------------------------------------------------
// Encoder period averager assertion macros
// Shared property shapes for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_AVERAGER_ASSERT_SVH
`define ENCODER_PERIOD_AVERAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("encoder_period_averager: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("encoder_period_averager: next-cycle check failed");

`endif

>>> hdl/epa_pkg.sv
// ----------------------------------------------------------------------------
// Encoder period averager package
// Shared widths, constants, codes and controller interface types.
// ----------------------------------------------------------------------------
package epa_pkg;

  // Window geometry.
  localparam int MAX_WINDOW_LOG2 = 5;
  localparam int WIN_SLOTS       = 1 << MAX_WINDOW_LOG2;
  localparam int IDX_W           = MAX_WINDOW_LOG2;
  localparam int FILL_W          = IDX_W + 1;
  localparam int PER_W           = 31;
  localparam int SUM_W           = PER_W + IDX_W;
  localparam int EFF_SHIFT_W     = $clog2(MAX_WINDOW_LOG2 + 1);

  // Field and register widths.
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int SHIFT_W = 3;
  localparam int TPM_W   = 16;
  localparam int MS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Constants.
  localparam logic [MS_W-1:0]   STALE_MS    = MS_W'(60000);
  localparam logic [MS_W-1:0]   ELAPSED_MAX = '1;
  localparam logic [TPM_W-1:0]  DEFAULT_TPM = TPM_W'(7812);
  localparam logic [SHIFT_W-1:0] DEFAULT_SHIFT = SHIFT_W'(1);
  localparam logic [WORD_W-1:0] ALL_ONES    = '1;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } epa_op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_SHIFT  = 2'd1,
    CFG_TPM    = 2'd2,
    CFG_SPARE  = 2'd3
  } epa_cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAMP_SUB,
    ST_SAMP_ADD,
    ST_RD_MUL1,
    ST_RD_MUL2,
    ST_RD_FIN,
    ST_DONE
  } epa_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic exec;
    logic samp_sub;
    logic samp_add;
    logic rd_mul1;
    logic rd_mul2;
    logic rd_fin;
    logic load_out;
  } epa_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_sample;
    logic is_read_live;
    logic out_free;
  } epa_stat_t;

endpackage

>>> hdl/encoder_period_averager.sv
// ----------------------------------------------------------------------------
// Encoder period averager
// Quadrature encoder tick counter with a moving average of encoder periods.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall with in_command (sample, one ms
// tick, read period, or an unused code) and in_sample_word. Every request
// gives exactly one result on out_valid/out_stall: the signed tick count, the
// period report (reads only) and whether a sample was taken.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while idle, which the block itself does not enforce.
// Ticks, ignored samples, disabled or stale reads and unused codes pass from
// execute to done; samples add a window memory read, sum subtract and sum
// add, and live reads two passes through one 16x16 multiplier, compare and
// report. Requests are handled one at a time.
// A finished result waits in the output register while the next request is
// accepted; a request that finishes while the receiver still stalls the
// previous result holds until that result is taken.
// Reset clears the counters, window state and result valid; registers return
// to disabled, window exponent 1 and 7812 ticks per ms. The window memory
// itself is not cleared: only entries written since the last clear are read.
// ----------------------------------------------------------------------------
`include "encoder_period_averager_assert.svh"

module encoder_period_averager
  import epa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [WORD_W-1:0]        in_sample_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_tick_count,
  output logic [WORD_W-1:0]        out_period_report,
  output logic                     out_sample_taken,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  epa_ctl_t  ctl;
  epa_stat_t stat;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  epa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Window, arithmetic and result register.
  epa_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .in_command        (in_command),
    .in_sample_word    (in_sample_word),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tick_count    (out_tick_count),
    .out_period_report (out_period_report),
    .out_sample_taken  (out_sample_taken)
  );

  // Only one request is in flight at a time.
  `EPA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // A sample result never carries a period report.
  `EPA_ASSERT_SAME(a_sample_no_report, clk, rst_n, out_valid && out_sample_taken, out_period_report == '0)

  // The input reopens only after a result was loaded.
  `EPA_ASSERT_SAME(a_reopen_after_load, clk, rst_n, $fell(in_stall), $past(ctl.load_out))

endmodule

>>> hdl/epa_ctrl.sv
// ----------------------------------------------------------------------------
// Encoder period averager controller
// Sequences one request at a time through the datapath steps.
// ----------------------------------------------------------------------------
module epa_ctrl
  import epa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  epa_stat_t stat,
  output epa_ctl_t  ctl
);

  epa_state_t state_r;
  epa_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (stat.is_sample) state_nxt = ST_SAMP_SUB;
        else if (stat.is_read_live)  state_nxt = ST_RD_MUL1;
        else                         state_nxt = ST_DONE;
      end
      ST_SAMP_SUB: state_nxt = ST_SAMP_ADD;
      ST_SAMP_ADD: state_nxt = ST_DONE;
      ST_RD_MUL1:  state_nxt = ST_RD_MUL2;
      ST_RD_MUL2:  state_nxt = ST_RD_FIN;
      ST_RD_FIN:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      ST_EXEC:     ctl.exec     = 1'b1;
      ST_SAMP_SUB: ctl.samp_sub = 1'b1;
      ST_SAMP_ADD: ctl.samp_add = 1'b1;
      ST_RD_MUL1:  ctl.rd_mul1  = 1'b1;
      ST_RD_MUL2:  ctl.rd_mul2  = 1'b1;
      ST_RD_FIN:   ctl.rd_fin   = 1'b1;
      ST_DONE:     ctl.load_out = stat.out_free;
      default:     ctl          = '0;
    endcase
  end

endmodule

>>> hdl/epa_datapath.sv
// ----------------------------------------------------------------------------
// Encoder period averager datapath
// Configuration, period window with running sum, staleness math and the
// result register.
// ----------------------------------------------------------------------------
module epa_datapath
  import epa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  epa_ctl_t                ctl,
  output epa_stat_t               stat,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [WORD_W-1:0]       in_sample_word,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WORD_W-1:0] out_tick_count,
  output logic [WORD_W-1:0]       out_period_report,
  output logic                    out_sample_taken
);

  // Configuration registers.
  logic               enable_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [TPM_W-1:0]   tpm_r;

  // Block state.
  logic [IDX_W-1:0]  wi_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic              cur_dir_r;
  logic [WORD_W-1:0] ticks_r;
  logic [MS_W-1:0]   elapsed_r;
  logic [PER_W-1:0]  lat_per_r;
  logic              lat_dir_r;

  // Request and working registers.
  epa_op_t           op_r;
  logic [WORD_W-1:0] word_r;
  logic [PER_W-1:0]  rdata_r;
  logic [WORD_W-1:0] mul_r;
  logic              slow_r;
  logic [WORD_W-1:0] report_r;
  logic              taken_r;

  // Result register.
  logic              out_valid_r;
  logic [WORD_W-1:0] out_ticks_r;
  logic [WORD_W-1:0] out_report_r;
  logic              out_taken_r;

  logic [PER_W-1:0] win_mem [WIN_SLOTS];

  logic [EFF_SHIFT_W-1:0] eff_shift;
  logic [FILL_W-1:0]      win_len;
  logic [IDX_W-1:0]       win_mask;
  logic [TPM_W-1:0]       tpm_eff;
  logic [PER_W-1:0]       per;
  logic                   dir;
  logic                   dir_change;
  logic [IDX_W-1:0]       wi_eff;
  logic [MS_W-1:0]        mul_a;
  logic                   cfg_we;

  // Clamp the window exponent into the supported range.
  always_comb begin
    priority if (shift_r == '0) begin
      eff_shift = EFF_SHIFT_W'(1);
    end else if (int'(shift_r) > MAX_WINDOW_LOG2) begin
      eff_shift = EFF_SHIFT_W'(MAX_WINDOW_LOG2);
    end else begin
      eff_shift = EFF_SHIFT_W'(shift_r);
    end
  end

  assign win_len    = FILL_W'(1) << eff_shift;
  assign win_mask   = IDX_W'(win_len - FILL_W'(1));
  assign tpm_eff    = (tpm_r == '0) ? TPM_W'(1) : tpm_r;
  assign per        = word_r[WORD_W-1:1];
  assign dir        = word_r[0];
  assign dir_change = (dir != cur_dir_r);
  assign wi_eff     = dir_change ? '0 : (wi_r & win_mask);
  assign cfg_we     = cfg_valid;

  // Status toward the controller.
  assign stat.is_sample    = (op_r == OP_SAMPLE) && enable_r;
  assign stat.is_read_live = (op_r == OP_READ) && enable_r && (elapsed_r <= STALE_MS);
  assign stat.out_free     = !out_valid_r || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      shift_r  <= DEFAULT_SHIFT;
      tpm_r    <= DEFAULT_TPM;
    end else if (cfg_we) begin
      unique case (epa_cfg_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_SHIFT:  shift_r  <= cfg_data[SHIFT_W-1:0];
        CFG_TPM:    tpm_r    <= cfg_data[TPM_W-1:0];
        CFG_SPARE:  ;
      endcase
    end
  end

  // Window pointer, fill count and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r      <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      cur_dir_r <= 1'b0;
    end else if (cfg_we && (epa_cfg_t'(cfg_index) == CFG_SHIFT)) begin
      wi_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (ctl.exec && stat.is_sample) begin
      // A direction change restarts the window.
      wi_r      <= wi_eff;
      cur_dir_r <= dir;
      if (dir_change) begin
        fill_r <= '0;
        sum_r  <= '0;
      end
    end else if (ctl.samp_sub) begin
      // A full window drops its oldest period.
      if (fill_r >= win_len) begin
        sum_r  <= sum_r - SUM_W'(rdata_r);
        fill_r <= win_len - FILL_W'(1);
      end
    end else if (ctl.samp_add) begin
      sum_r  <= sum_r + SUM_W'(per);
      wi_r   <= (wi_r + IDX_W'(1)) & win_mask;
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // Window memory with registered read.
  always_ff @(posedge clk) begin
    if (ctl.samp_add) begin
      win_mem[wi_r] <= per;
    end
    if (ctl.exec) begin
      rdata_r <= win_mem[wi_eff];
    end
  end

  // Tick count, elapsed time and the latched average.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= '0;
      elapsed_r <= '0;
      lat_per_r <= '0;
      lat_dir_r <= 1'b0;
    end else if (ctl.exec) begin
      unique case (op_r)
        OP_SAMPLE: begin
          if (enable_r) begin
            ticks_r   <= dir ? ticks_r + WORD_W'(1) : ticks_r - WORD_W'(1);
            elapsed_r <= '0;
          end
        end
        OP_TICK: begin
          if (elapsed_r != ELAPSED_MAX) elapsed_r <= elapsed_r + MS_W'(1);
        end
        OP_READ: begin
          if (enable_r && (fill_r == win_len)) begin
            lat_per_r <= PER_W'(sum_r >> eff_shift);
            lat_dir_r <= cur_dir_r;
          end
        end
        OP_NONE: ;
      endcase
    end
  end

  // Shared multiplier: whole sixteenths of elapsed ms, then elapsed ms.
  assign mul_a = ctl.rd_mul1 ? MS_W'(elapsed_r[MS_W-1:4]) : elapsed_r;

  // Request capture and report formation.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r     <= epa_op_t'(in_command);
      word_r   <= in_sample_word;
      report_r <= '0;
      taken_r  <= 1'b0;
    end
    if (ctl.exec) begin
      if ((op_r == OP_SAMPLE) && enable_r) taken_r <= 1'b1;
      if ((op_r == OP_READ) && !stat.is_read_live) report_r <= ALL_ONES;
    end
    if (ctl.rd_mul1 || ctl.rd_mul2) begin
      mul_r <= WORD_W'(mul_a * tpm_eff);
    end
    // Quiet encoder: the average is below the whole sixteenths of elapsed ms, in timer ticks.
    if (ctl.rd_mul2) begin
      slow_r <= WORD_W'(lat_per_r) < mul_r;
    end
    if (ctl.rd_fin) begin
      report_r <= slow_r ? {mul_r[WORD_W-2:0], lat_dir_r} : {lat_per_r, lat_dir_r};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_ticks_r  <= ticks_r;
      out_report_r <= report_r;
      out_taken_r  <= taken_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tick_count    = out_ticks_r;
  assign out_period_report = out_report_r;
  assign out_sample_taken  = out_taken_r;

endmodule

>>> sim/encoder_period_averager_checker.sv
// ----------------------------------------------------------------------------
// Encoder period averager result checker
// Watches the request, result and register channels of the averager, keeps
// its own copy of the tick count, period window and register state, works out
// the result of every accepted request and compares each delivered result
// field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_period_averager_checker
  import epa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [WORD_W-1:0]        in_sample_word,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [WORD_W-1:0] out_tick_count,
  input  logic [WORD_W-1:0]        out_period_report,
  input  logic                     out_sample_taken,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       pending_count,
  output int                       checked_count
);

  localparam int unsigned SLOW_FACTOR = 16;

  typedef struct {
    logic signed [WORD_W-1:0] tick_count;
    logic [WORD_W-1:0]        period_report;
    logic                     sample_taken;
  } enc_result_t;

  // Register copies.
  logic                 en_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [TPM_W-1:0]     tpm_q;

  // Window and counter copies.
  logic [PER_W-1:0]     win_mem [WIN_SLOTS];
  logic [IDX_W-1:0]     wr_idx;
  logic [FILL_W-1:0]    fill;
  logic [SUM_W-1:0]     win_sum;
  logic                 cur_dir;
  logic [WORD_W-1:0]    ticks;
  logic [MS_W-1:0]      elapsed;
  logic [PER_W-1:0]     lat_per;
  logic                 lat_dir;

  // Results of accepted requests that have not been delivered yet.
  enc_result_t          owed_results[$];

  function automatic int unsigned window_log2();
    int unsigned s;
    s = shift_q;
    if (s < 1) s = 1;
    if (s > MAX_WINDOW_LOG2) s = MAX_WINDOW_LOG2;
    return s;
  endfunction

  function automatic void clear_window();
    wr_idx  = '0;
    fill    = '0;
    win_sum = '0;
  endfunction

  // Folds one encoder sample into the tick count and the period window.
  function automatic void absorb_sample(input logic [WORD_W-1:0] word);
    logic             dir;
    logic [PER_W-1:0] per;
    int unsigned      len;
    dir = word[0];
    per = word[WORD_W-1:1];
    len = 1 << window_log2();
    ticks = dir ? ticks + 1 : ticks - 1;
    if (dir != cur_dir) clear_window();
    cur_dir = dir;
    wr_idx = wr_idx & IDX_W'(len - 1);
    // A full window drops its oldest period before taking the new one.
    if (fill >= len) begin
      win_sum = win_sum - win_mem[wr_idx];
      fill    = FILL_W'(len - 1);
    end
    win_sum = win_sum + per;
    win_mem[wr_idx] = per;
    wr_idx  = IDX_W'((wr_idx + 1) & (len - 1));
    fill    = fill + 1;
    elapsed = '0;
  endfunction

  // Works out the period report of a read and updates the latched average.
  function automatic logic [WORD_W-1:0] period_reading();
    int unsigned      s;
    logic [63:0]      tpm64;
    logic [63:0]      per_ms;
    logic [63:0]      adj;
    s     = window_log2();
    tpm64 = (tpm_q == '0) ? 64'd1 : {48'd0, tpm_q};
    if (!en_q) return ALL_ONES;
    if (fill == (1 << s)) begin
      lat_per = PER_W'(win_sum >> s);
      lat_dir = cur_dir;
    end
    if (elapsed > STALE_MS) return ALL_ONES;
    per_ms = {33'd0, lat_per} / tpm64 + 64'd1;
    // A quiet encoder reports the time since its last edge, in timer ticks.
    if ({48'd0, elapsed} >= per_ms * SLOW_FACTOR) begin
      adj = {48'd0, elapsed} * tpm64;
      return {adj[WORD_W-2:0], lat_dir};
    end
    return {lat_per, lat_dir};
  endfunction

  function automatic enc_result_t run_request(input epa_op_t op,
                                              input logic [WORD_W-1:0] word);
    enc_result_t r;
    r.period_report = '0;
    r.sample_taken  = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (en_q) begin
          absorb_sample(word);
          r.sample_taken = 1'b1;
        end
      end
      OP_TICK: begin
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1;
      end
      OP_READ: begin
        r.period_report = period_reading();
      end
      default: begin
      end
    endcase
    r.tick_count = ticks;
    return r;
  endfunction

  // Channel watch: reset, register writes, delivered results, new requests.
  always @(posedge clk) begin
    enc_result_t want;
    if (!rst_n) begin
      en_q    = 1'b0;
      shift_q = DEFAULT_SHIFT;
      tpm_q   = DEFAULT_TPM;
      clear_window();
      cur_dir = 1'b0;
      ticks   = '0;
      elapsed = '0;
      lat_per = '0;
      lat_dir = 1'b0;
      owed_results.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (epa_cfg_t'(cfg_index))
          CFG_ENABLE: en_q = cfg_data[0];
          CFG_SHIFT: begin
            shift_q = cfg_data[SHIFT_W-1:0];
            clear_window();
          end
          CFG_TPM:    tpm_q = cfg_data[TPM_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result delivered with no request outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          checked_count++;
          if (out_tick_count !== want.tick_count) begin
            $error("tick_count mismatch: expected %0d, actual %0d",
                   want.tick_count, out_tick_count);
            fail_count++;
          end
          if (out_period_report !== want.period_report) begin
            $error("period_report mismatch: expected 0x%08h, actual 0x%08h",
                   want.period_report, out_period_report);
            fail_count++;
          end
          if (out_sample_taken !== want.sample_taken) begin
            $error("sample_taken mismatch: expected %0b, actual %0b",
                   want.sample_taken, out_sample_taken);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        owed_results.push_back(run_request(epa_op_t'(in_command), in_sample_word));
      end
    end
    pending_count = owed_results.size();
  end

endmodule

>>> sim/encoder_period_averager_tb.sv
// ----------------------------------------------------------------------------
// Encoder period averager testbench
// Drives encoder samples, millisecond ticks and period reads through the
// averager under bursty requests and a patterned receiver, over a range of
// register settings, and leaves all result checking to the checker module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_period_averager_tb;
  import epa_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 55;
  localparam int HOLD_CYCLES  = 400;

  // Receiver stall patterns.
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_BEAT  = 3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command;
  logic [WORD_W-1:0]        in_sample_word;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_tick_count;
  logic [WORD_W-1:0]        out_period_report;
  logic                     out_sample_taken;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;

  // Sender pacing and receiver control.
  int  burst_left;
  bit  steady;
  bit  rx_quiet;
  int  hold_asks;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  rx_mode = RX_FREE;
  int  rx_left = 0;
  int  n_requests;
  int  n_writes;
  int  cycles;

  encoder_period_averager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_sample_word    (in_sample_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tick_count    (out_tick_count),
    .out_period_report (out_period_report),
    .out_sample_taken  (out_sample_taken),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  encoder_period_averager_checker averager_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_sample_word    (in_sample_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tick_count    (out_tick_count),
    .out_period_report (out_period_report),
    .out_sample_taken  (out_sample_taken),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver: a long hold-off when asked, otherwise a changing stall pattern.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (rx_quiet) begin
      out_stall = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_BEAT);
        rx_left = $urandom_range(32, 400);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:  out_stall = 1'b0;
        RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
        default:  out_stall = ((rx_left % 5) < 2);
      endcase
    end
  end

  // Offers one request and waits until it is taken; starts and ends at a
  // falling edge, leaving valid high for a following request unless a burst gap lowered it.
  task automatic offer_request(input epa_op_t op, input logic [WORD_W-1:0] word);
    in_valid       = 1'b1;
    in_command     = op;
    in_sample_word = word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_requests++;
    // Burst pacing: a random gap, which may be empty, closes each burst.
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
      end
    end
  endtask

  // Stops offering and waits until every request has produced its result.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input epa_cfg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_writes++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) offer_request(OP_TICK, $urandom());
  endtask

  // Random traffic for one register setting: mostly same-direction sample
  // runs that fill the window, with reads, tick bursts and some noise.
  task automatic random_traffic(input int phase);
    int          done;
    int          roll;
    int          n;
    int          scale;
    logic        dir;
    logic [30:0] per;
    bit          pressed;
    done    = 0;
    scale   = 12;
    pressed = 1'b0;
    dir     = $urandom_range(0, 1);
    while (done < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (phase == 2 && !pressed) begin
        // Long receiver hold-off while requests keep coming.
        pressed = 1'b1;
        hold_asks++;
        steady = 1'b1;
        repeat (20) offer_request(epa_op_t'($urandom_range(0, 1) ? OP_READ : OP_SAMPLE),
                                  {31'($urandom_range(0, 500)), dir});
        steady = 1'b0;
        done += 20;
      end else if (phase == 4 && !pressed && done >= 30) begin
        pressed = 1'b1;
        drain_results();
        offer_request(OP_READ, $urandom());
        done++;
      end else if (roll < 55) begin
        if ($urandom_range(0, 99) < 4) dir = ~dir;
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 3))
            0:       scale = 4;
            1:       scale = 12;
            2:       scale = 20;
            default: scale = 31;
          endcase
        end
        per = 31'($urandom()) & 31'((64'd1 << scale) - 1);
        if ($urandom_range(0, 49) == 0) per = '1;
        offer_request(OP_SAMPLE, {per, dir});
        done++;
      end else if (roll < 70) begin
        offer_request(OP_READ, $urandom());
        done++;
      end else if (roll < 84) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(1, 40);
        tick_run(n);
        done += n;
      end else if (roll < 90) begin
        offer_request(OP_NONE, $urandom());
      end else begin
        offer_request(OP_SAMPLE, $urandom());
        done++;
      end
    end
  endtask

  // Run-length watchdog.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycles, pending_count);
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [SHIFT_W-1:0] sh;
    logic [TPM_W-1:0]   tpm;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = OP_NONE;
    in_sample_word = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_data       = '0;
    burst_left     = 1;
    steady         = 1'b0;
    rx_quiet       = 1'b0;
    hold_asks      = 0;
    n_requests     = 0;
    n_writes       = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Out of reset the block is disabled: samples are ignored, ticks count.
    offer_request(OP_SAMPLE, 32'hFFFF_FFFF);
    offer_request(OP_TICK, 32'h0);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_NONE, 32'hFFFF_FFFF);
    drain_results();

    // Zero window exponent and zero ticks per ms act as one; spare index.
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_SHIFT, 16'h0000);
    write_reg(CFG_TPM, 16'h0000);
    write_reg(CFG_SPARE, 16'hFFFF);
    offer_request(OP_SAMPLE, 32'hFFFF_FFFF);
    offer_request(OP_SAMPLE, 32'h0000_0001);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_SAMPLE, 32'h0000_0000);
    offer_request(OP_SAMPLE, 32'hFFFF_FFFE);
    offer_request(OP_READ, 32'hFFFF_FFFF);
    tick_run(3);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_NONE, 32'h0);
    drain_results();

    // Exponent above the window limit, largest ticks per ms.
    write_reg(CFG_SHIFT, 16'h0007);
    write_reg(CFG_TPM, 16'hFFFF);
    offer_request(OP_SAMPLE, 32'h0000_0011);
    offer_request(OP_SAMPLE, 32'h0000_0021);
    offer_request(OP_READ, 32'h0);
    drain_results();

    // Disabled again: sample ignored, read reports all ones.
    write_reg(CFG_ENABLE, 16'h0000);
    offer_request(OP_SAMPLE, 32'h0000_0101);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_TICK, 32'h0);
    drain_results();

    // Quiet encoder: elapsed time just below, at and past the slow threshold.
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_SHIFT, 16'h0001);
    write_reg(CFG_TPM, 16'hFFFF);
    offer_request(OP_SAMPLE, 32'h0000_0021);
    offer_request(OP_SAMPLE, 32'h0000_0041);
    offer_request(OP_READ, 32'h0);
    steady   = 1'b1;
    rx_quiet = 1'b1;
    tick_run(15);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_TICK, 32'h0);
    offer_request(OP_READ, 32'h0);
    tick_run(40);
    offer_request(OP_READ, 32'h0);
    offer_request(OP_SAMPLE, 32'h0000_0021);
    offer_request(OP_READ, 32'h0);
    steady   = 1'b0;
    rx_quiet = 1'b0;
    drain_results();

    // Random phases, the first ones at the register extremes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       begin sh = 3'd1; tpm = 16'd1;     end
        1:       begin sh = 3'd5; tpm = 16'hFFFF;  end
        2:       begin sh = 3'd0; tpm = 16'd0;     end
        4:       begin sh = 3'd7; tpm = 16'($urandom()); end
        default: begin sh = 3'($urandom_range(0, 7)); tpm = 16'($urandom()); end
      endcase
      write_reg(CFG_ENABLE, (p == 3) ? 16'h0000 : 16'h0001);
      write_reg(CFG_SHIFT, {13'd0, sh});
      write_reg(CFG_TPM, tpm);
      random_traffic(p);
      drain_results();
    end

    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d requests and %0d register writes in %0d cycles",
             n_requests, n_writes, cycles);
    $display("results compared: %0d, mismatches: %0d", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
